>>> rtl/core/rgbpwm_pkg.sv
// Shared types and constants for the RGB strip PWM frame encoder.
`default_nettype none

package rgbpwm_pkg;

   localparam int LEN_W   = 7;
   localparam int DEPTH_W = 4;
   localparam int DUTY_W  = 8;
   localparam int IDX_W   = 6;
   localparam int BYTE_W  = 8;

   // Configuration register indexes
   localparam logic CSR_STRIP_LENGTH = 1'b0;
   localparam logic CSR_BIT_DEPTH    = 1'b1;

   // Input item function codes
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FRAME = 1'b1;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;

   // Command byte bits
   localparam logic [BYTE_W-1:0] BYTE_MARK  = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_RED   = 8'h04;
   localparam logic [BYTE_W-1:0] BYTE_GREEN = 8'h10;
   localparam logic [BYTE_W-1:0] BYTE_BLUE  = 8'h01;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic             pix_wr;
      logic             issue;
      logic             issue_last;
      logic             issue_marker;
      logic [LEN_W-1:0] issue_idx;
   } cmd_type;

   typedef struct packed {
      logic             advance;
      logic             len_zero;
      logic [LEN_W-1:0] strip_len;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/rgbpwm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rgbpwm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/rgbpwm_ctrl.sv
// Frame sequencer: accepts items and walks the LEDs of a frame.
`default_nettype none

module rgbpwm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_func,
   input  wire rgbpwm_pkg::status_type status,
   output rgbpwm_pkg::cmd_type         cmd
);

   rgbpwm_pkg::state_type state_ff, state_in;
   logic [rgbpwm_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic accept;
   logic at_last;

   assign accept  = req_valid && !req_stall;
   assign at_last = status.len_zero
                    || ((8'(cnt_ff) + 8'd1) == 8'(status.strip_len));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgbpwm_pkg::ST_IDLE: begin
            if (accept && (req_func == rgbpwm_pkg::FUNC_FRAME)) begin
               state_in = rgbpwm_pkg::ST_WALK;
            end
         end
         rgbpwm_pkg::ST_WALK: begin
            if (status.advance && at_last) begin
               state_in = rgbpwm_pkg::ST_IDLE;
            end
         end
         default: state_in = rgbpwm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = 1'b1;
      cmd.pix_wr       = 1'b0;
      cmd.issue        = 1'b0;
      cmd.issue_last   = at_last;
      cmd.issue_marker = status.len_zero;
      cmd.issue_idx    = cnt_ff;
      cnt_in           = cnt_ff;
      case (state_ff)
         rgbpwm_pkg::ST_IDLE: begin
            // input side is open here, so valid alone takes the item
            req_stall  = 1'b0;
            cmd.pix_wr = req_valid && (req_func == rgbpwm_pkg::FUNC_PIXEL);
            cnt_in     = '0;
         end
         rgbpwm_pkg::ST_WALK: begin
            // advance one LED whenever the pipeline moves
            cmd.issue = status.advance;
            if (status.advance) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbpwm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/rgbpwm_datapath.sv
// Duty store, configuration registers, PWM phase and byte output stage.
`default_nettype none

module rgbpwm_datapath #(
   parameter int MAX_LEDS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rgbpwm_pkg::cmd_type                 cmd,
   output rgbpwm_pkg::status_type                   status,
   input  wire logic [rgbpwm_pkg::IDX_W-1:0]        req_pixel_index,
   input  wire logic [rgbpwm_pkg::DUTY_W-1:0]       req_red_duty,
   input  wire logic [rgbpwm_pkg::DUTY_W-1:0]       req_green_duty,
   input  wire logic [rgbpwm_pkg::DUTY_W-1:0]       req_blue_duty,
   input  wire logic                                csr_write_en,
   input  wire logic                                csr_index,
   input  wire logic [rgbpwm_pkg::LEN_W-1:0]        csr_wdata,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic      [rgbpwm_pkg::BYTE_W-1:0]       rsp_strip_byte,
   output logic                                     rsp_byte_valid,
   output logic                                     rsp_latch
);

   localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int RAM_W = 3 * rgbpwm_pkg::DUTY_W;
   localparam logic [7:0] MAX_LEDS_B = 8'(MAX_LEDS);

   logic [rgbpwm_pkg::LEN_W-1:0]   strip_len_ff, strip_len_in;
   logic [rgbpwm_pkg::DEPTH_W-1:0] bit_depth_ff, bit_depth_in;
   logic [rgbpwm_pkg::DUTY_W-1:0]  phase_ff, phase_in;
   logic [MAX_LEDS-1:0]            entry_valid_ff, entry_valid_in;

   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff, s1_last_in;
   logic s1_marker_ff, s1_marker_in;
   logic s1_on_ff, s1_on_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rgbpwm_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                          rsp_bv_ff, rsp_bv_in;
   logic                          rsp_latch_ff, rsp_latch_in;

   logic             advance;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic [RAM_W-1:0] rd_data;
   logic [rgbpwm_pkg::DUTY_W-1:0] red_q, green_q, blue_q;
   logic [rgbpwm_pkg::DEPTH_W-1:0] depth_eff;
   logic [rgbpwm_pkg::DUTY_W-1:0]  phase_step;
   logic [rgbpwm_pkg::LEN_W-1:0]   len_sat;
   logic [rgbpwm_pkg::BYTE_W-1:0]  led_byte;

   assign advance = !rsp_valid_ff || !rsp_stall;

   assign status.advance   = advance;
   assign status.len_zero  = (strip_len_ff == '0);
   assign status.strip_len = strip_len_ff;

   // drop pixel writes beyond the strip
   assign wr_en   = cmd.pix_wr
                    && (8'(req_pixel_index) < 8'(strip_len_ff))
                    && (8'(req_pixel_index) < MAX_LEDS_B);
   assign wr_addr = AW'(req_pixel_index);
   assign rd_addr = AW'(cmd.issue_idx);

   rgbpwm_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_LEDS)
   ) u_duty_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_red_duty, req_green_duty, req_blue_duty}),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an entry never written since the last length write reads as zero
   assign red_q   = s1_on_ff ? rd_data[RAM_W-1 -: rgbpwm_pkg::DUTY_W] : '0;
   assign green_q = s1_on_ff ? rd_data[rgbpwm_pkg::DUTY_W +: rgbpwm_pkg::DUTY_W] : '0;
   assign blue_q  = s1_on_ff ? rd_data[rgbpwm_pkg::DUTY_W-1:0] : '0;

   always_comb begin
      led_byte = rgbpwm_pkg::BYTE_MARK;
      if (phase_ff < red_q) begin
         led_byte = led_byte | rgbpwm_pkg::BYTE_RED;
      end
      if (phase_ff < green_q) begin
         led_byte = led_byte | rgbpwm_pkg::BYTE_GREEN;
      end
      if (phase_ff < blue_q) begin
         led_byte = led_byte | rgbpwm_pkg::BYTE_BLUE;
      end
   end

   always_comb begin
      depth_eff = bit_depth_ff;
      if (bit_depth_ff < rgbpwm_pkg::DEPTH_MIN) begin
         depth_eff = rgbpwm_pkg::DEPTH_MIN;
      end else if (bit_depth_ff > rgbpwm_pkg::DEPTH_MAX) begin
         depth_eff = rgbpwm_pkg::DEPTH_MAX;
      end
      phase_step = 8'(9'd256 >> depth_eff);
   end

   assign len_sat = (8'(csr_wdata) > MAX_LEDS_B) ? rgbpwm_pkg::LEN_W'(MAX_LEDS) : csr_wdata;

   always_comb begin
      strip_len_in   = strip_len_ff;
      bit_depth_in   = bit_depth_ff;
      entry_valid_in = entry_valid_ff;
      if (csr_write_en) begin
         case (csr_index)
            rgbpwm_pkg::CSR_STRIP_LENGTH: begin
               strip_len_in   = len_sat;
               entry_valid_in = '0;
            end
            rgbpwm_pkg::CSR_BIT_DEPTH: begin
               bit_depth_in = csr_wdata[rgbpwm_pkg::DEPTH_W-1:0];
            end
            default: begin
               strip_len_in = strip_len_ff;
            end
         endcase
      end
      if (wr_en) begin
         entry_valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_last_in   = s1_last_ff;
      s1_marker_in = s1_marker_ff;
      s1_on_in     = s1_on_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_latch_in = rsp_latch_ff;
      phase_in     = phase_ff;
      if (advance) begin
         s1_valid_in  = cmd.issue;
         s1_last_in   = cmd.issue_last;
         s1_marker_in = cmd.issue_marker;
         s1_on_in     = entry_valid_ff[rd_addr];
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_byte_in  = s1_marker_ff ? '0 : led_byte;
            rsp_bv_in    = !s1_marker_ff;
            rsp_latch_in = s1_last_ff;
            // step the phase once the last byte of the frame is formed
            if (s1_last_ff) begin
               phase_in = phase_ff + phase_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff   <= '0;
         bit_depth_ff   <= rgbpwm_pkg::DEPTH_RESET;
         phase_ff       <= '0;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         strip_len_ff   <= strip_len_in;
         bit_depth_ff   <= bit_depth_in;
         phase_ff       <= phase_in;
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_marker_ff <= s1_marker_in;
      s1_on_ff     <= s1_on_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_latch_ff <= rsp_latch_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_strip_byte = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_latch      = rsp_latch_ff;

endmodule

`default_nettype wire

>>> rtl/core/rgb_strip_pwm_frame_encoder.sv
// Top level of the RGB strip PWM frame encoder.
// Input channel (req_*): func 0 stores red, green and blue duties for one LED
// (ignored at or beyond the strip length); func 1 is a frame tick. Each item
// is taken when req_valid is high and req_stall is low.
// Result channel (rsp_*): a frame tick gives one command byte per LED, in LED
// order, with rsp_latch on the last one; an empty strip gives one marker with
// rsp_byte_valid low. A pixel write gives nothing.
// The first byte of a frame passes the sequencer's walk state, the RAM read
// stage and the output register, then one byte per cycle while the receiver
// takes them. A pixel write leaves the input side open; a frame tick holds
// it until the walk has issued its last LED, set by the single read port of
// the duty RAM, which the sequencer walks one LED per cycle unless stalled.
// A stall on rsp_stall freezes the read pipeline and the output register; the
// walk resumes where it stopped. A new item is taken while the last byte of a
// frame still waits to be collected.
// Configuration (csr_*): index 0 strip length (clears all duties), index 1 bit
// depth. Write only while the block is idle.
// Reset (synchronous): strip length 0, bit depth 3, phase 0, all duties zero.
`default_nettype none

module rgb_strip_pwm_frame_encoder #(
   parameter int MAX_LEDS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [5:0]  req_pixel_index,
   input  wire logic [7:0]  req_red_duty,
   input  wire logic [7:0]  req_green_duty,
   input  wire logic [7:0]  req_blue_duty,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_strip_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_latch,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata
);

   rgbpwm_pkg::cmd_type    cmd;
   rgbpwm_pkg::status_type status;

   rgbpwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   rgbpwm_datapath #(
      .MAX_LEDS (MAX_LEDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_index (req_pixel_index),
      .req_red_duty    (req_red_duty),
      .req_green_duty  (req_green_duty),
      .req_blue_duty   (req_blue_duty),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_strip_byte  (rsp_strip_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_latch       (rsp_latch)
   );

`ifndef SYNTHESIS
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_latch && (rsp_strip_byte == 8'h00)))
      else $error("empty-strip marker malformed");

   a_led_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> rsp_strip_byte[7])
      else $error("LED byte without bit 7");

   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (req_stall && !cmd.pix_wr))
      else $error("read issued while input side open");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.issue_marker) |=> !cmd.issue)
      else $error("walk continued after empty-strip marker");
`endif

endmodule

`default_nettype wire
